// ===== hdl/qrf_pkg.sv =====
// ----------------------------------------------------------------------------
// qrf_pkg
// Shared types, register codes and constants of the QR finder row detector.
// ----------------------------------------------------------------------------
package qrf_pkg;

  localparam int DEF_MAX_ROW_WIDTH = 4096;

  localparam int RUN_W   = 13;  // run length and module width
  localparam int RNUM_W  = 3;   // run number 0..5
  localparam int TENTH_W = 6;   // bound registers
  localparam int PROD_W  = RUN_W + TENTH_W;
  localparam int CIDX_W  = 3;

  // Run numbers within a row.
  localparam logic [RNUM_W-1:0] RUN_MODULE   = 3'd0;
  localparam logic [RNUM_W-1:0] RUN_LIGHT1   = 3'd1;
  localparam logic [RNUM_W-1:0] RUN_CENTER   = 3'd2;
  localparam logic [RNUM_W-1:0] RUN_LIGHT2   = 3'd3;
  localparam logic [RNUM_W-1:0] RUN_DARK_END = 3'd4;
  localparam logic [RNUM_W-1:0] RUNS_DONE    = 3'd5;

  typedef enum logic [CIDX_W-1:0] {
    CFG_LIGHT1_MIN   = 3'd0,
    CFG_LIGHT1_MAX   = 3'd1,
    CFG_CENTER_MIN   = 3'd2,
    CFG_CENTER_MAX   = 3'd3,
    CFG_LIGHT2_MIN   = 3'd4,
    CFG_LIGHT2_MAX   = 3'd5,
    CFG_DARK_END_MIN = 3'd6,
    CFG_DARK_END_MAX = 3'd7
  } cfg_idx_t;

  typedef struct packed {
    logic [TENTH_W-1:0] light1_min;
    logic [TENTH_W-1:0] light1_max;
    logic [TENTH_W-1:0] center_min;
    logic [TENTH_W-1:0] center_max;
    logic [TENTH_W-1:0] light2_min;
    logic [TENTH_W-1:0] light2_max;
    logic [TENTH_W-1:0] dark_end_min;
    logic [TENTH_W-1:0] dark_end_max;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    light1_min:   6'd9,
    light1_max:   6'd12,
    center_min:   6'd28,
    center_max:   6'd36,
    light2_min:   6'd8,
    light2_max:   6'd12,
    dark_end_min: 6'd8,
    dark_end_max: 6'd12
  };

  typedef struct packed {
    logic [TENTH_W-1:0] lo;
    logic [TENTH_W-1:0] hi;
  } bounds_t;

  // Bounds of one checked run; the module run and the done code have none.
  function automatic bounds_t run_bounds(input cfg_t cfg, input logic [RNUM_W-1:0] run);
    bounds_t b;
    b = '0;
    case (run)
      RUN_LIGHT1:   b = '{lo: cfg.light1_min,   hi: cfg.light1_max};
      RUN_CENTER:   b = '{lo: cfg.center_min,   hi: cfg.center_max};
      RUN_LIGHT2:   b = '{lo: cfg.light2_min,   hi: cfg.light2_max};
      RUN_DARK_END: b = '{lo: cfg.dark_end_min, hi: cfg.dark_end_max};
      default:      b = '0;
    endcase
    return b;
  endfunction

endpackage

// ===== hdl/qrf_if.sv =====
// ----------------------------------------------------------------------------
// qrf_pix_if / qrf_res_if
// Valid/ready channels for pixels in and row results out.
// ----------------------------------------------------------------------------
interface qrf_pix_if;
  logic valid;
  logic ready;
  logic pixel_light;
  logic row_end;

  modport source (output valid, output pixel_light, output row_end, input ready);
  modport sink   (input valid, input pixel_light, input row_end, output ready);
endinterface

interface qrf_res_if;
  import qrf_pkg::*;
  logic             valid;
  logic             ready;
  logic             row_match;
  logic [RUN_W-1:0] module_width;

  modport source (output valid, output row_match, output module_width, input ready);
  modport sink   (input valid, input row_match, input module_width, output ready);
endinterface

// ===== hdl/qrf_run_check.sv =====
// ----------------------------------------------------------------------------
// qrf_run_check
// Checks lo*module <= 10*len <= hi*module by integer cross-multiplication.
// ----------------------------------------------------------------------------
module qrf_run_check (
  input  qrf_pkg::bounds_t           bnd,
  input  logic [qrf_pkg::RUN_W-1:0] module_len,
  input  logic [qrf_pkg::RUN_W-1:0] run_len,
  output logic                       ok
);
  import qrf_pkg::*;

  logic [PROD_W-1:0] lo_prod;
  logic [PROD_W-1:0] hi_prod;
  logic [PROD_W-1:0] scaled;

  assign lo_prod = PROD_W'(bnd.lo) * PROD_W'(module_len);
  assign hi_prod = PROD_W'(bnd.hi) * PROD_W'(module_len);
  // Ten times the run length as 8x + 2x.
  assign scaled  = (PROD_W'(run_len) << 3) + (PROD_W'(run_len) << 1);
  assign ok      = (scaled >= lo_prod) && (scaled <= hi_prod);

endmodule

// ===== hdl/qr_finder_row_detector_unit.sv =====
// ----------------------------------------------------------------------------
// qr_finder_row_detector_unit
// Streams binarized row pixels and reports whether each row opens with the
// 1:1:3:1:1 finder ratio, together with the module width.
// ----------------------------------------------------------------------------
//  Channel   Dir  Payload                     Transfer
//  in_ch     in   pixel_light, row_end        valid & ready
//  out_ch    out  row_match, module_width     valid & ready, one per row end
//  cfg_*     in   cfg_index, cfg_wdata        cfg_we, eight 6-bit bounds
//
//  One pixel is taken every cycle while in_ch.ready is high; the row result is
//  registered, or held in the skid entry while out_ch stalls. Run tracking and
//  both bound checks sit between the run state registers and the result register.
//  Reset (rst_n low, synchronous) restores the default bounds and row start.
//  The result register is backed by a skid entry; in_ch.ready drops only
//  while the skid entry holds a result.
// ----------------------------------------------------------------------------
module qr_finder_row_detector_unit #(
  parameter int MAX_ROW_WIDTH = qrf_pkg::DEF_MAX_ROW_WIDTH
) (
  input  logic                       clk,
  input  logic                       rst_n,
  qrf_pix_if.sink                    in_ch,
  qrf_res_if.source                  out_ch,
  input  logic                       cfg_we,
  input  logic [qrf_pkg::CIDX_W-1:0] cfg_index,
  input  logic [qrf_pkg::TENTH_W-1:0] cfg_wdata
);
  import qrf_pkg::*;

  localparam logic [RUN_W-1:0] RUN_CAP =
    RUN_W'((MAX_ROW_WIDTH < 8191) ? MAX_ROW_WIDTH : 8191);

  cfg_t cfg_r;

  logic [RUN_W-1:0]  cnt_r, mod_r;
  logic [RNUM_W-1:0] rn_r;
  logic              prev_r, fail_r, start_r;

  logic [RUN_W-1:0]  cnt_a, mod_a, mod_b;
  logic [RNUM_W-1:0] rn_a;
  logic              prev_a, fail_a, fail_b;

  logic              ok_a, ok_b, tail_ok;
  bounds_t           bnd_a, bnd_b;

  logic              in_fire, res_valid, res_match;
  logic [RUN_W-1:0]  res_width;

  logic              out_valid_r, out_match_r;
  logic [RUN_W-1:0]  out_width_r;
  logic              skid_valid_r, skid_match_r;
  logic [RUN_W-1:0]  skid_width_r;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RESET;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_LIGHT1_MIN:   cfg_r.light1_min   <= cfg_wdata;
        CFG_LIGHT1_MAX:   cfg_r.light1_max   <= cfg_wdata;
        CFG_CENTER_MIN:   cfg_r.center_min   <= cfg_wdata;
        CFG_CENTER_MAX:   cfg_r.center_max   <= cfg_wdata;
        CFG_LIGHT2_MIN:   cfg_r.light2_min   <= cfg_wdata;
        CFG_LIGHT2_MAX:   cfg_r.light2_max   <= cfg_wdata;
        CFG_DARK_END_MIN: cfg_r.dark_end_min <= cfg_wdata;
        CFG_DARK_END_MAX: cfg_r.dark_end_max <= cfg_wdata;
      endcase
    end
  end

  assign in_ch.ready = !skid_valid_r;
  assign in_fire     = in_ch.valid && in_ch.ready;

  // Check of the run that a colour change closes.
  assign bnd_a = run_bounds(cfg_r, rn_r);
  qrf_run_check u_check_a (
    .bnd        (bnd_a),
    .module_len (mod_r),
    .run_len    (cnt_r),
    .ok         (ok_a)
  );

  // Check of the run that the row end cuts off.
  assign bnd_b = run_bounds(cfg_r, rn_a);
  qrf_run_check u_check_b (
    .bnd        (bnd_b),
    .module_len (mod_a),
    .run_len    (cnt_a),
    .ok         (ok_b)
  );

  // Runs never started have length zero and pass only with a zero minimum.
  assign tail_ok = ((rn_a >= RUN_LIGHT1)   || (cfg_r.light1_min   == '0)) &&
                   ((rn_a >= RUN_CENTER)   || (cfg_r.center_min   == '0)) &&
                   ((rn_a >= RUN_LIGHT2)   || (cfg_r.light2_min   == '0)) &&
                   ((rn_a >= RUN_DARK_END) || (cfg_r.dark_end_min == '0));

  always_comb begin
    cnt_a  = cnt_r;
    mod_a  = mod_r;
    rn_a   = rn_r;
    prev_a = prev_r;
    fail_a = fail_r;
    if (start_r) begin
      fail_a = in_ch.pixel_light;
      rn_a   = RUN_MODULE;
      cnt_a  = RUN_W'(1);
      prev_a = 1'b0;
    end else if (!fail_r && (rn_r < RUNS_DONE)) begin
      if (in_ch.pixel_light == prev_r) begin
        if (cnt_r < RUN_CAP) begin
          cnt_a = cnt_r + RUN_W'(1);
        end
      end else begin
        if (rn_r == RUN_MODULE) begin
          mod_a = cnt_r;
        end else if (!ok_a) begin
          fail_a = 1'b1;
        end
        rn_a   = rn_r + RNUM_W'(1);
        cnt_a  = RUN_W'(1);
        prev_a = in_ch.pixel_light;
      end
    end

    fail_b = fail_a;
    mod_b  = mod_a;
    if (!fail_a && (rn_a < RUNS_DONE)) begin
      if (rn_a == RUN_MODULE) begin
        mod_b = cnt_a;
      end else if (!ok_b) begin
        fail_b = 1'b1;
      end
      if (!tail_ok) begin
        fail_b = 1'b1;
      end
    end

    res_valid = in_fire && in_ch.row_end;
    res_match = !fail_b;
    res_width = res_match ? mod_b : '0;
  end

  // Run state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r   <= '0;
      mod_r   <= '0;
      rn_r    <= RUN_MODULE;
      prev_r  <= 1'b0;
      fail_r  <= 1'b0;
      start_r <= 1'b1;
    end else if (in_fire) begin
      if (in_ch.row_end) begin
        cnt_r   <= '0;
        mod_r   <= '0;
        rn_r    <= RUN_MODULE;
        prev_r  <= 1'b0;
        fail_r  <= 1'b0;
        start_r <= 1'b1;
      end else begin
        cnt_r   <= cnt_a;
        mod_r   <= mod_a;
        rn_r    <= rn_a;
        prev_r  <= prev_a;
        fail_r  <= fail_a;
        start_r <= 1'b0;
      end
    end
  end

  // Result register with a skid entry behind it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (!out_valid_r || out_ch.ready) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r  <= res_valid;
      end
    end else if (res_valid) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || out_ch.ready) begin
      if (skid_valid_r) begin
        out_match_r <= skid_match_r;
        out_width_r <= skid_width_r;
      end else begin
        out_match_r <= res_match;
        out_width_r <= res_width;
      end
    end else if (res_valid) begin
      skid_match_r <= res_match;
      skid_width_r <= res_width;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.row_match    = out_match_r;
  assign out_ch.module_width = out_width_r;

  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry holds a result while the result register is empty");

  a_width_follows_match: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_match_r == (out_width_r != '0)))
    else $error("module width disagrees with match flag");

  a_row_end_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_ch.row_end) |=> (start_r && (rn_r == RUN_MODULE) && !fail_r))
    else $error("row end did not restart the run tracker");

  a_run_number_range: assert property (@(posedge clk) disable iff (!rst_n)
    rn_r <= RUNS_DONE)
    else $error("run number out of range");

  a_count_capped: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= RUN_CAP)
    else $error("run length above cap");

endmodule
